/* sv/r10bp_pkg.sv */
// Shared constants, types and helpers for the raw10 Bayer half-res preview block.
`timescale 1ns / 1ps
package r10bp_pkg;

	// Line store geometry
	localparam int MAX_LINE   = 4096;
	localparam int PAIR_DEPTH = MAX_LINE / 2;
	localparam int PAIR_AW    = $clog2(PAIR_DEPTH);

	// Field and counter widths
	localparam int COL_W = 13;
	localparam int ROW_W = 12;
	localparam int PIX_W = 8;
	localparam int CFG_W = 13;

	localparam logic [COL_W-1:0] MAX_W          = COL_W'(MAX_LINE);
	localparam logic [COL_W-1:0] LINE_WIDTH_RST = 13'd3840;
	localparam logic [ROW_W-1:0] LINE_PAIRS_RST = 12'd1080;

	// Configuration register indexes
	localparam logic REG_LINE_WIDTH = 1'b0;
	localparam logic REG_LINE_PAIRS = 1'b1;

	// One preview pixel
	typedef struct packed {
		logic             eof;
		logic             eol;
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pixel_t;

	// Usable line width: even, clamped to 2..MAX_LINE
	function automatic logic [COL_W-1:0] eff_width(input logic [COL_W-1:0] lw);
		logic [COL_W-1:0] w;
		w = lw & 13'h1FFE;
		if (w < 13'd2) w = 13'd2;
		if (w > MAX_W) w = MAX_W;
		return w;
	endfunction

endpackage

/* sv/raw10_unpack_bayer_half_res_preview.sv */
// Top level: packed raw10 Bayer stream to half-resolution RGB preview pixels.
//
//  channel  | dir | payload                                     | handshake
//  ---------+-----+---------------------------------------------+---------------------
//  s_*      | in  | tdata[7:0] data_byte, tuser frame_start     | tvalid/tready
//  m_*      | out | tdata blue,green,red; tlast eol; tuser eof  | tvalid/tready
//  cfg_*    | in  | cfg_addr reg index, cfg_wdata value         | cfg_we, no wait
//
// One byte per cycle while s_tready is high; a pixel leaves on every second
// bottom-row sample, so at most one per byte and two per five bytes.
// A pixel goes to the output register, or to the skid stage while it is stalled.
// The top row lives in two 2048-entry byte RAMs (even/odd samples); the pair
// needed by a bottom-row pixel is read ahead, from the next column state.
// Reset clears counters and phase; the line store is not cleared.
// s_tready drops only when both the output register and skid stage are full.
`timescale 1ns / 1ps
module raw10_unpack_bayer_half_res_preview (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] data_byte
	input  logic                        s_tuser,   // [0] frame_start
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [23:0]                 m_tdata,   // [7:0] blue, [15:8] green, [23:16] red
	output logic                        m_tlast,   // end_of_line
	output logic                        m_tuser,   // [0] end_of_frame
	input  logic                        cfg_we,
	input  logic                        cfg_addr,
	input  logic [r10bp_pkg::CFG_W-1:0] cfg_wdata
);
	import r10bp_pkg::*;

	logic [COL_W-1:0] line_width_q;
	logic [ROW_W-1:0] line_pairs_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [PIX_W-1:0] red_q;

	logic             acc;
	logic [COL_W-1:0] w;
	logic [COL_W:0]   w2;
	logic [COL_W-1:0] col0;
	logic [ROW_W-1:0] row0;
	logic             pre_wrap;
	logic [COL_W-1:0] col1;
	logic [ROW_W-1:0] row1;
	logic [ROW_W-1:0] row_inc;
	logic             active;
	logic [PIX_W-1:0] sample;
	logic             sample_valid;
	logic             use_s;
	logic [COL_W:0]   cn;
	logic             end_pair;
	logic [COL_W-1:0] col_after;
	logic [ROW_W-1:0] row_after;
	logic             is_top;
	logic [COL_W-1:0] cb;
	logic             store_we;
	logic [COL_W-1:0] line_width_nx;
	logic [COL_W-1:0] col_nx;
	logic [COL_W-1:0] cb_nx;
	logic [PAIR_AW-1:0] rd_addr;
	logic [PAIR_AW-1:0] wr_addr;
	logic [PIX_W-1:0] rd_even;
	logic [PIX_W-1:0] rd_odd;
	logic [PIX_W:0]   gsum;
	logic             push;
	logic             buf_ready;
	pixel_t           pix;
	pixel_t           pix_out;

	assign acc = s_tvalid & s_tready;

	// column/row after frame start and the close of a pair cut short by a width change
	always_comb begin
		w        = eff_width(line_width_q);
		w2       = {w, 1'b0};
		col0     = s_tuser ? '0 : col_q;
		row0     = s_tuser ? '0 : row_q;
		pre_wrap = {1'b0, col0} >= w2;
		col1     = pre_wrap ? '0 : col0;
		row1     = (pre_wrap && row0 != '1) ? row0 + 1'b1 : row0;
		active   = row1 < line_pairs_q;
		row_inc  = row1 + 1'b1;
	end

	r10bp_unpack u_unpack (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_in      (s_tdata),
		.frame_start  (s_tuser),
		.accept       (acc),
		.active       (active),
		.sample       (sample),
		.sample_valid (sample_valid)
	);

	// column advance and sample routing
	always_comb begin
		use_s     = acc & active & sample_valid;
		cn        = {1'b0, col1} + 1'b1;
		end_pair  = cn >= w2;
		col_after = use_s ? (end_pair ? '0 : cn[COL_W-1:0]) : col1;
		row_after = (use_s && end_pair) ? row_inc : row1;
		is_top    = col1 < w;
		cb        = col1 - w;
		store_we  = use_s & is_top;
		wr_addr   = col1[PAIR_AW:1];
		push      = use_s & ~is_top & cb[0];
	end

	// next-cycle read address follows the column and width the next byte will see
	always_comb begin
		line_width_nx = (cfg_we && cfg_addr == REG_LINE_WIDTH) ? cfg_wdata : line_width_q;
		col_nx        = acc ? col_after : col_q;
		cb_nx         = col_nx - eff_width(line_width_nx);
		rd_addr       = cb_nx[PAIR_AW:1];
	end

	// top-row line store, split by sample parity
	r10bp_ram #(.DEPTH(PAIR_DEPTH), .WIDTH(PIX_W)) u_store_even (
		.clk   (clk),
		.we    (store_we & ~col1[0]),
		.waddr (wr_addr),
		.wdata (sample),
		.raddr (rd_addr),
		.rdata (rd_even)
	);

	r10bp_ram #(.DEPTH(PAIR_DEPTH), .WIDTH(PIX_W)) u_store_odd (
		.clk   (clk),
		.we    (store_we & col1[0]),
		.waddr (wr_addr),
		.wdata (sample),
		.raddr (rd_addr),
		.rdata (rd_odd)
	);

	// pixel assembly
	always_comb begin
		gsum      = {1'b0, rd_even} + {1'b0, sample};
		pix.blue  = rd_odd;
		pix.green = gsum[PIX_W:1];
		pix.red   = red_q;
		pix.eol   = cb == (w - 1'b1);
		pix.eof   = pix.eol && (row_inc == line_pairs_q);
	end

	// config registers and frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RST;
			line_pairs_q <= LINE_PAIRS_RST;
			col_q        <= '0;
			row_q        <= '0;
			red_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_LINE_WIDTH: line_width_q <= cfg_wdata;
					REG_LINE_PAIRS: line_pairs_q <= cfg_wdata[ROW_W-1:0];
					default: ;
				endcase
			end
			if (acc) begin
				col_q <= col_after;
				row_q <= row_after;
			end
			if (use_s && !is_top && !cb[0]) begin
				red_q <= sample;
			end
		end
	end

	r10bp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pix_in    (pix),
		.ready     (buf_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.pix_out   (pix_out)
	);

	assign s_tready = buf_ready;
	assign m_tdata  = {pix_out.red, pix_out.green, pix_out.blue};
	assign m_tlast  = pix_out.eol;
	assign m_tuser  = pix_out.eof;

endmodule

/* sv/r10bp_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM with registered read.
`timescale 1ns / 1ps
module r10bp_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/r10bp_unpack.sv */
// Unpacker for 10-bit samples packed four to five bytes, keeps the upper 8 bits.
`timescale 1ns / 1ps
module r10bp_unpack (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [7:0]                byte_in,
	input  logic                      frame_start,
	input  logic                      accept,
	input  logic                      active,
	output logic [r10bp_pkg::PIX_W-1:0] sample,
	output logic                      sample_valid
);
	import r10bp_pkg::*;

	typedef enum logic [2:0] {
		PH_LEAD = 3'd0,
		PH_B1   = 3'd1,
		PH_B2   = 3'd2,
		PH_B3   = 3'd3,
		PH_B4   = 3'd4
	} phase_t;

	phase_t     phase_q;
	logic [7:0] carry_q;

	phase_t     ph;
	phase_t     ph_nx;
	logic [7:0] cr;
	logic [7:0] cr_nx;

	// frame start clears phase and leftover bits before the byte is used
	always_comb begin
		ph = frame_start ? PH_LEAD : phase_q;
		cr = frame_start ? 8'd0 : carry_q;
	end

	// splice leftover bits with the top of the new byte
	always_comb begin
		sample       = '0;
		sample_valid = 1'b1;
		cr_nx        = 8'd0;
		ph_nx        = PH_LEAD;
		case (ph)
			PH_B1: begin
				sample = cr;
				cr_nx  = byte_in & 8'h3F;
				ph_nx  = PH_B2;
			end
			PH_B2: begin
				sample = {cr[5:0], byte_in[7:6]};
				cr_nx  = byte_in & 8'h0F;
				ph_nx  = PH_B3;
			end
			PH_B3: begin
				sample = {cr[3:0], byte_in[7:4]};
				cr_nx  = byte_in & 8'h03;
				ph_nx  = PH_B4;
			end
			PH_B4: begin
				sample = {cr[1:0], byte_in[7:2]};
				cr_nx  = 8'd0;
				ph_nx  = PH_LEAD;
			end
			default: begin
				// lead byte, or a phase code that means nothing
				sample_valid = 1'b0;
				cr_nx        = byte_in;
				ph_nx        = PH_B1;
			end
		endcase
	end

	// phase and leftover bits; past the frame only the clear applies
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			carry_q <= 8'd0;
		end else if (accept) begin
			if (active) begin
				phase_q <= ph_nx;
				carry_q <= cr_nx;
			end else begin
				phase_q <= ph;
				carry_q <= cr;
			end
		end
	end

endmodule

/* sv/r10bp_outbuf.sv */
// Output register plus skid stage for preview pixels.
`timescale 1ns / 1ps
module r10bp_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  r10bp_pkg::pixel_t pix_in,
	output logic              ready,
	output logic              out_valid,
	input  logic              out_ready,
	output r10bp_pkg::pixel_t pix_out
);
	import r10bp_pkg::*;

	logic   out_v_q;
	logic   skid_v_q;
	pixel_t out_q;
	pixel_t skid_q;
	logic   pop;

	assign pop       = out_v_q & out_ready;
	assign ready     = ~skid_v_q;
	assign out_valid = out_v_q;
	assign pix_out   = out_q;

	// control: skid fills only while the output word is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			out_q <= skid_v_q ? skid_q : pix_in;
		end else if (push) begin
			skid_q <= pix_in;
		end
	end

`ifndef NO_ASSERTIONS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a word while the output register is empty");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!ready |-> out_valid)
		else $error("input stalled with no output word pending");

	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> out_valid)
		else $error("pushed word not presented on the next cycle");
`endif

endmodule

/* sim/tb_raw10_unpack_bayer_half_res_preview.sv */
// Testbench for the raw10 Bayer half-res preview: directed and random byte streams vs. a predictor.
`timescale 1ns / 1ps
module tb_raw10_unpack_bayer_half_res_preview;
	import r10bp_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;

	localparam pixel_t NO_PIXEL = '0;
	localparam pixel_t FULL_MID = '{eof: 1'b0, eol: 1'b0, red: 8'hFF, green: 8'hFF, blue: 8'hFF};
	localparam pixel_t FULL_END = '{eof: 1'b1, eol: 1'b1, red: 8'hFF, green: 8'hFF, blue: 8'hFF};

	// One directed word; a typed pixel replaces the predicted one
	typedef struct {
		logic [7:0] data;
		logic       fs;
		bit         typed;
		pixel_t     want;
	} stim_row_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata   = '0;
	logic              s_tuser   = 1'b0;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [23:0]       m_tdata;
	logic              m_tlast;
	logic              m_tuser;
	logic              cfg_we    = 1'b0;
	logic              cfg_addr  = REG_LINE_WIDTH;
	logic [CFG_W-1:0]  cfg_wdata = '0;

	// Predictor state
	int unsigned cur_width = LINE_WIDTH_RST;
	int unsigned cur_pairs = LINE_PAIRS_RST;
	int unsigned phase_pos = 0;
	int unsigned carry     = 0;
	int unsigned column    = 0;
	int unsigned pair_row  = 0;
	logic [7:0]  red_hold  = '0;
	logic [7:0]  top_line [MAX_LINE];
	bit          top_valid [MAX_LINE];

	pixel_t pending_pixels [$];
	int     errors      = 0;
	int     tx_idle_pct = 0;
	int     rx_idle_pct = 0;
	bit     hold_req    = 1'b0;
	int     hold_left   = 0;

	// Directed stream at width 4, one row pair per frame
	stim_row_t directed_rows [25] = '{
		'{8'hFF, 1'b1, 1'b0, NO_PIXEL},  // all-ones frame
		'{8'hFF, 1'b0, 1'b0, NO_PIXEL},
		'{8'hFF, 1'b0, 1'b0, NO_PIXEL},
		'{8'hFF, 1'b0, 1'b0, NO_PIXEL},
		'{8'hFF, 1'b0, 1'b0, NO_PIXEL},
		'{8'hFF, 1'b0, 1'b0, NO_PIXEL},
		'{8'hFF, 1'b0, 1'b0, NO_PIXEL},
		'{8'hFF, 1'b0, 1'b1, FULL_MID},
		'{8'hFF, 1'b0, 1'b0, NO_PIXEL},
		'{8'hFF, 1'b0, 1'b1, FULL_END},
		'{8'h5A, 1'b0, 1'b0, NO_PIXEL},  // past the frame, ignored
		'{8'h80, 1'b1, 1'b0, NO_PIXEL},  // mixed-bit frame
		'{8'h40, 1'b0, 1'b0, NO_PIXEL},
		'{8'h01, 1'b0, 1'b0, NO_PIXEL},
		'{8'hA5, 1'b0, 1'b0, NO_PIXEL},
		'{8'h3C, 1'b0, 1'b0, NO_PIXEL},
		'{8'hC3, 1'b0, 1'b0, NO_PIXEL},
		'{8'h7E, 1'b0, 1'b0, NO_PIXEL},
		'{8'h81, 1'b0, 1'b0, NO_PIXEL},
		'{8'h18, 1'b0, 1'b0, NO_PIXEL},
		'{8'hE7, 1'b0, 1'b0, NO_PIXEL},
		'{8'h12, 1'b1, 1'b0, NO_PIXEL},  // short frame, restarted mid group by the next frame start
		'{8'hFE, 1'b0, 1'b0, NO_PIXEL},
		'{8'h00, 1'b1, 1'b0, NO_PIXEL},
		'{8'h7F, 1'b0, 1'b0, NO_PIXEL}
	};

	raw10_unpack_bayer_half_res_preview dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	// Even sample count per line, clamped to the store size
	function automatic int unsigned usable_width();
		int unsigned w;
		w = cur_width & 13'h1FFE;
		if (w < 2) w = 2;
		if (w > MAX_LINE) w = MAX_LINE;
		return w;
	endfunction

	// True if a plain word now would read a top-line entry never written
	function automatic bit bottom_read_unsafe();
		int unsigned w, c, r;
		w = usable_width();
		c = column;
		r = pair_row;
		if (c >= 2 * w) begin
			c = 0;
			if (r < 12'hFFF) r++;
		end
		if (r >= cur_pairs || phase_pos < 1 || phase_pos > 4 || c < w) return 1'b0;
		c -= w;
		if (!c[0]) return 1'b0;
		return !(top_valid[c - 1] && top_valid[c]);
	endfunction

	// Unpack one byte, bin the 2x2 quad, return the pixel it completes
	task automatic bin_byte(input logic [7:0] b, input logic fs, output bit got,
			output pixel_t px);
		int unsigned w, s, c;
		got = 1'b0;
		px  = NO_PIXEL;
		w   = usable_width();
		if (fs) begin
			phase_pos = 0;
			carry     = 0;
			column    = 0;
			pair_row  = 0;
		end
		// width shrunk under the current pair: close it
		if (column >= 2 * w) begin
			column = 0;
			if (pair_row < 12'hFFF) pair_row++;
		end
		if (pair_row >= cur_pairs) return;
		case (phase_pos)
			1: begin
				s = carry;
				carry = b & 8'h3F;
				phase_pos = 2;
			end
			2: begin
				s = ((carry & 8'h3F) << 2) | (b >> 6);
				carry = b & 8'h0F;
				phase_pos = 3;
			end
			3: begin
				s = ((carry & 8'h0F) << 4) | (b >> 4);
				carry = b & 8'h03;
				phase_pos = 4;
			end
			4: begin
				s = ((carry & 8'h03) << 6) | (b >> 2);
				carry = 0;
				phase_pos = 0;
			end
			default: begin
				carry = b;
				phase_pos = 1;
				return;
			end
		endcase
		c = column;
		column = c + 1;
		if (column >= 2 * w) begin
			column = 0;
			pair_row++;
		end
		// top row: G,B,G,B...
		if (c < w) begin
			top_line[c]  = s[7:0];
			top_valid[c] = 1'b1;
			return;
		end
		// bottom row: R,G,R,G...
		c -= w;
		if (!c[0]) begin
			red_hold = s[7:0];
			return;
		end
		px.blue  = top_line[c];
		px.green = 8'((top_line[c - 1] + s) >> 1);
		px.red   = red_hold;
		px.eol   = (c == w - 1);
		px.eof   = px.eol && (pair_row == cur_pairs);
		got      = 1'b1;
	endtask

	// Offer one word, wait for it to be taken, then predict
	task automatic send_word(input logic [7:0] b, input logic fs, input bit typed,
			input pixel_t want);
		bit     got;
		pixel_t px;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= fs;
		do @(posedge clk); while (!s_tready);
		bin_byte(b, fs, got, px);
		if (typed) pending_pixels.push_back(want);
		else if (got) pending_pixels.push_back(px);
	endtask

	// Stop offering and wait for every expected pixel to come out
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Drain, pick idle rates, write both registers
	task automatic next_phase(input int regime, input logic [12:0] lw, input logic [12:0] lp);
		settle();
		case (regime)
			0: begin tx_idle_pct = 15; rx_idle_pct = 67; end
			1: begin tx_idle_pct = 67; rx_idle_pct = 15; end
			default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
		endcase
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_LINE_WIDTH;
		cfg_wdata <= lw;
		@(posedge clk);
		cfg_addr  <= REG_LINE_PAIRS;
		cfg_wdata <= lp;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_width = lw;
		cur_pairs = lp & 12'hFFF;
	endtask

	// Mostly whole frames of random bytes, with stray words and broken frames
	task automatic stream_phase(input int n_words, input int noise_pct, input int min_col,
			input int hold_at);
		logic [7:0] b;
		logic       fs;
		int         pick;
		for (int i = 0; i < n_words || column < min_col; i++) begin
			if (i == hold_at) hold_req = 1'b1;
			pick = $urandom_range(15);
			if (pick == 0) b = 8'h00;
			else if (pick == 1) b = 8'hFF;
			else b = 8'($urandom_range(255));
			if (pair_row >= cur_pairs) fs = ($urandom_range(3) != 0);
			else fs = ($urandom_range(99) < noise_pct);
			if (!fs && bottom_read_unsafe()) fs = 1'b1;
			send_word(b, fs, 1'b0, NO_PIXEL);
		end
	endtask

	// Receiver: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Pixel checker
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel: tdata %h tlast %b tuser %b", m_tdata, m_tlast, m_tuser);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				if (m_tdata[7:0] !== want.blue) begin
					$error("blue: expected %0d, got %0d", want.blue, m_tdata[7:0]);
					errors++;
				end
				if (m_tdata[15:8] !== want.green) begin
					$error("green: expected %0d, got %0d", want.green, m_tdata[15:8]);
					errors++;
				end
				if (m_tdata[23:16] !== want.red) begin
					$error("red: expected %0d, got %0d", want.red, m_tdata[23:16]);
					errors++;
				end
				if (m_tlast !== want.eol) begin
					$error("end_of_line: expected %b, got %b", want.eol, m_tlast);
					errors++;
				end
				if (m_tuser !== want.eof) begin
					$error("end_of_frame: expected %b, got %b", want.eof, m_tuser);
					errors++;
				end
			end
		end
	end

	// Main sequence
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		next_phase(0, 13'd4, 13'd1);
		foreach (directed_rows[k])
			send_word(directed_rows[k].data, directed_rows[k].fs, directed_rows[k].typed,
				directed_rows[k].want);
		stream_phase(200, 2, 0, -1);

		// end inside a bottom row so the narrower width closes the pair
		next_phase(1, 13'd10, 13'd3);
		stream_phase(250, 2, 14, -1);
		next_phase(2, 13'd7, 13'd2);
		stream_phase(200, 2, 0, -1);
		next_phase(0, 13'd0, 13'd2);
		stream_phase(150, 2, 0, -1);
		// no pixels at all with zero row pairs
		next_phase(1, 13'd3, 13'd0);
		stream_phase(40, 2, 0, -1);
		// top row of a frame at the widest line
		next_phase(2, 13'h1FFF, 13'd1);
		stream_phase(200, 0, 0, -1);
		next_phase(0, 13'd12, 13'h1FFF);
		stream_phase(200, 2, 0, -1);
		// output held off while the input keeps pushing
		next_phase(2, 13'd8, 13'd5);
		stream_phase(250, 2, 0, 60);
		next_phase(1, 13'd20, 13'd1);
		stream_phase(100, 2, 0, -1);

		settle();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog
	initial begin
		#200_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
